// ===== hdl/soi_pkg.sv =====
// Shared types and constants for the sparse octree voxel insert block.
// Used by the channel interfaces, the controller, the datapath and the top level.
package soi_pkg;

    localparam int MAX_DEPTH      = 10;
    localparam int NODE_CAPACITY  = 65536;
    localparam int COLOR_CAPACITY = 65536;

    localparam int NODE_AW  = $clog2(NODE_CAPACITY);
    localparam int COLOR_AW = $clog2(COLOR_CAPACITY);
    localparam int CNT_W    = 17;
    localparam int CODE_W   = 30;
    localparam int RGB_W    = 24;
    localparam int IDX_W    = 16;
    localparam int OFFS_W   = 16;
    localparam int DEPTH_W  = 4;
    localparam int WORD_W   = 32;
    localparam int GROUP    = 8;

    typedef enum logic [1:0] {
        CMD_INSERT     = 2'd0,
        CMD_READ_NODE  = 2'd1,
        CMD_READ_COLOR = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_ORDER = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_RD,
        S_WAIT,
        S_UPD,
        S_CLR,
        S_ADV,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    latch;
        logic    init_root;
        logic    rd;
        logic    wr_leaf;
        logic    wr_inner;
        logic    clr_step;
        logic    step;
        logic    set_status;
        status_t status_val;
        logic    load_out;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_insert;
        logic is_read_node;
        logic is_read_color;
        logic bad_order;
        logic full;
        logic idx_ok;
        logic last_level;
        logic need_alloc;
        logic stop;
        logic clr_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/soi_req_if.sv =====
// Request channel: one command item with valid/ready handshake.
// Depends on soi_pkg for field widths.
interface soi_req_if
    import soi_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [1:0]          command;
    logic [CODE_W-1:0]   voxel_code;
    logic [RGB_W-1:0]    color;
    logic [IDX_W-1:0]    read_index;

    modport source (output valid, command, voxel_code, color, read_index, input ready);
    modport sink   (input valid, command, voxel_code, color, read_index, output ready);
endinterface

// ===== hdl/soi_rsp_if.sv =====
// Response channel: one result item per request, valid/ready handshake.
// Depends on soi_pkg for field widths.
interface soi_rsp_if
    import soi_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [7:0]          node_valid_mask;
    logic [7:0]          node_leaf_mask;
    logic [OFFS_W-1:0]   node_child_offset;
    logic [RGB_W-1:0]    color_out;
    logic [CNT_W-1:0]    node_count;
    logic [CNT_W-1:0]    color_count;

    modport source (output valid, status, node_valid_mask, node_leaf_mask, node_child_offset,
                    color_out, node_count, color_count, input ready);
    modport sink   (input valid, status, node_valid_mask, node_leaf_mask, node_child_offset,
                    color_out, node_count, color_count, output ready);
endinterface

// ===== hdl/soi_datapath.sv =====
// Datapath: node and color memories, counters, walk registers and output register.
// Depends on soi_pkg; driven by soi_ctrl through ctrl_cmd_t.
module soi_datapath
    import soi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [DEPTH_W-1:0] cfg_wr_data,
    input  logic [1:0]        in_command,
    input  logic [CODE_W-1:0] in_code,
    input  logic [RGB_W-1:0]  in_color,
    input  logic [IDX_W-1:0]  in_index,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        st,
    soi_rsp_if.source         out_ch
);

    // memories
    logic [WORD_W-1:0] node_mem  [NODE_CAPACITY];
    logic [RGB_W-1:0]  color_mem [COLOR_CAPACITY];
    logic [WORD_W-1:0] node_rd_reg;
    logic [RGB_W-1:0]  color_rd_reg;

    // state
    logic [DEPTH_W-1:0] tree_depth_reg;
    logic [CNT_W-1:0]   nodes_used_reg, colors_used_reg;
    logic [CODE_W-1:0]  prev_code_reg;

    // latched request
    logic [1:0]         cmd_reg;
    logic [CODE_W-1:0]  code_reg;
    logic [RGB_W-1:0]   color_reg;
    logic [IDX_W-1:0]   idx_reg;
    status_t            status_reg;

    // walk
    logic [NODE_AW-1:0] node_reg, node_next_reg, clr_base_reg;
    logic [DEPTH_W-1:0] level_reg;
    logic [2:0]         clr_cnt_reg;

    // output register
    logic               out_valid_reg;
    logic [1:0]         o_status_reg;
    logic [7:0]         o_vmask_reg, o_lmask_reg;
    logic [OFFS_W-1:0]  o_offs_reg;
    logic [RGB_W-1:0]   o_color_reg;
    logic [CNT_W-1:0]   o_ncnt_reg, o_ccnt_reg;

    logic [DEPTH_W-1:0] depth_eff, lvl_rem;
    logic [4:0]         shift_amt;
    logic [2:0]         child;
    logic [7:0]         child_bit, rd_vmask, rd_lmask;
    logic [OFFS_W-1:0]  rd_offs, new_offs, leaf_offs;
    logic [17:0]        next_sum, need_nodes;
    logic               alloc;
    logic               nwe;
    logic [NODE_AW-1:0] nw_addr, rd_addr;
    logic [WORD_W-1:0]  nw_data;

    // effective depth and child select
    always_comb
    begin
        if (tree_depth_reg == '0)
            depth_eff = DEPTH_W'(1);
        else if (tree_depth_reg > DEPTH_W'(MAX_DEPTH))
            depth_eff = DEPTH_W'(MAX_DEPTH);
        else
            depth_eff = tree_depth_reg;
        lvl_rem   = depth_eff - DEPTH_W'(1) - level_reg;
        shift_amt = 5'(lvl_rem) * 5'd3;
        child     = 3'(code_reg >> shift_amt);
        child_bit = 8'(1) << child;
    end

    // node word decode and update
    always_comb
    begin
        rd_vmask  = node_rd_reg[31:24];
        rd_lmask  = node_rd_reg[23:16];
        rd_offs   = node_rd_reg[15:0];
        alloc     = (rd_offs == '0);
        new_offs  = alloc ? OFFS_W'(nodes_used_reg - CNT_W'(node_reg)) : rd_offs;
        leaf_offs = (rd_offs == '0 && rd_lmask == '0) ? OFFS_W'(colors_used_reg) : rd_offs;
        next_sum  = 18'(node_reg) + 18'(new_offs) + 18'(child);
        need_nodes = 18'(nodes_used_reg) + 18'({depth_eff - DEPTH_W'(1), 3'b000});
    end

    // status to controller
    always_comb
    begin
        st.is_insert     = (cmd_reg == CMD_INSERT);
        st.is_read_node  = (cmd_reg == CMD_READ_NODE);
        st.is_read_color = (cmd_reg == CMD_READ_COLOR);
        st.bad_order     = (code_reg < prev_code_reg);
        st.full          = (need_nodes > 18'(NODE_CAPACITY)) ||
                           (colors_used_reg >= CNT_W'(COLOR_CAPACITY));
        st.idx_ok        = st.is_read_node ? (CNT_W'(idx_reg) < nodes_used_reg)
                                           : (CNT_W'(idx_reg) < colors_used_reg);
        st.last_level    = (level_reg == depth_eff - DEPTH_W'(1));
        st.need_alloc    = alloc;
        st.stop          = (next_sum >= 18'(nodes_used_reg));
        st.clr_last      = (clr_cnt_reg == 3'd7);
        st.out_free      = !out_valid_reg || out_ch.ready;
    end

    // node memory write port select
    always_comb
    begin
        nwe     = 1'b0;
        nw_addr = node_reg;
        nw_data = '0;
        rd_addr = st.is_insert ? node_reg : NODE_AW'(idx_reg);
        if (cmd.init_root)
        begin
            nwe     = 1'b1;
            nw_addr = '0;
        end
        else if (cmd.wr_leaf)
        begin
            nwe     = 1'b1;
            nw_data = {rd_vmask | child_bit, rd_lmask | child_bit, leaf_offs};
        end
        else if (cmd.wr_inner)
        begin
            nwe     = 1'b1;
            nw_data = {rd_vmask | child_bit, rd_lmask, new_offs};
        end
        else if (cmd.clr_step)
        begin
            nwe     = 1'b1;
            nw_addr = clr_base_reg + NODE_AW'(clr_cnt_reg);
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (nwe)
            node_mem[nw_addr] <= nw_data;
        if (cmd.rd)
            node_rd_reg <= node_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_leaf)
            color_mem[COLOR_AW'(colors_used_reg)] <= color_reg;
        if (cmd.rd)
            color_rd_reg <= color_mem[COLOR_AW'(idx_reg)];
    end

    // request and walk payload
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg   <= in_command;
            code_reg  <= in_code;
            color_reg <= in_color;
            idx_reg   <= in_index;
            node_reg  <= '0;
            level_reg <= '0;
        end
        else if (cmd.step)
        begin
            node_reg  <= node_next_reg;
            level_reg <= level_reg + DEPTH_W'(1);
        end
        if (cmd.wr_inner)
            node_next_reg <= NODE_AW'(next_sum);
        if (cmd.wr_inner && alloc)
        begin
            clr_base_reg <= NODE_AW'(nodes_used_reg);
            clr_cnt_reg  <= '0;
        end
        else if (cmd.clr_step)
            clr_cnt_reg <= clr_cnt_reg + 3'd1;
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_depth_reg  <= DEPTH_W'(MAX_DEPTH);
            nodes_used_reg  <= CNT_W'(1);
            colors_used_reg <= '0;
            prev_code_reg   <= '0;
            status_reg      <= STAT_OK;
        end
        else
        begin
            if (cfg_wr_en)
                tree_depth_reg <= cfg_wr_data;
            if (cmd.latch)
                status_reg <= STAT_OK;
            else if (cmd.set_status)
                status_reg <= cmd.status_val;
            if (cmd.wr_inner && alloc)
                nodes_used_reg <= nodes_used_reg + CNT_W'(GROUP);
            if (cmd.wr_leaf)
                colors_used_reg <= colors_used_reg + CNT_W'(1);
            if (cmd.load_out && st.is_insert && status_reg == STAT_OK)
                prev_code_reg <= code_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            o_status_reg <= status_reg;
            o_vmask_reg  <= '0;
            o_lmask_reg  <= '0;
            o_offs_reg   <= '0;
            o_color_reg  <= '0;
            o_ncnt_reg   <= nodes_used_reg;
            o_ccnt_reg   <= colors_used_reg;
            if (status_reg == STAT_OK && st.is_read_node)
            begin
                o_vmask_reg <= rd_vmask;
                o_lmask_reg <= rd_lmask;
                o_offs_reg  <= rd_offs;
            end
            if (status_reg == STAT_OK && st.is_read_color)
                o_color_reg <= color_rd_reg;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.status            = o_status_reg;
    assign out_ch.node_valid_mask   = o_vmask_reg;
    assign out_ch.node_leaf_mask    = o_lmask_reg;
    assign out_ch.node_child_offset = o_offs_reg;
    assign out_ch.color_out         = o_color_reg;
    assign out_ch.node_count        = o_ncnt_reg;
    assign out_ch.color_count       = o_ccnt_reg;

endmodule

// ===== hdl/soi_ctrl.sv =====
// Controller state machine: sequences checks, the per-level tree walk and group clears.
// Depends on soi_pkg; talks to soi_datapath through ctrl_cmd_t / dp_status_t.
module soi_ctrl
    import soi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t st,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   done;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status_val = STAT_OK;
        done       = 1'b0;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_INIT:
            begin
                cmd.init_root = 1'b1;
                state_next    = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.is_insert)
                begin
                    if (st.bad_order)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status_val = STAT_ORDER;
                        done = 1'b1;
                    end
                    else if (st.full)
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status_val = STAT_FULL;
                        done = 1'b1;
                    end
                    else
                        state_next = S_RD;
                end
                else if (st.is_read_node || st.is_read_color)
                begin
                    if (st.idx_ok)
                        state_next = S_RD;
                    else
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status_val = STAT_RANGE;
                        done = 1'b1;
                    end
                end
                else
                    done = 1'b1;
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (st.is_insert)
                    state_next = S_UPD;
                else
                    done = 1'b1;
            end
            S_UPD:
            begin
                if (st.last_level)
                begin
                    cmd.wr_leaf = 1'b1;
                    done = 1'b1;
                end
                else
                begin
                    cmd.wr_inner = 1'b1;
                    if (st.need_alloc)
                        state_next = S_CLR;
                    else if (st.stop)
                        done = 1'b1;
                    else
                        state_next = S_ADV;
                end
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                    state_next = S_ADV;
            end
            S_ADV:
            begin
                cmd.step   = 1'b1;
                state_next = S_RD;
            end
            S_DONE:
            begin
                // response goes out once the output register is free
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // status and memory updates settle before the response is loaded
        if (done)
            state_next = S_DONE;
    end

    // assertions
    a_wait_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WAIT |-> $past(state_reg) == S_RD)
        else $error("memory wait without read");
    a_clr_to_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR && st.clr_last) |=> state_reg == S_ADV)
        else $error("group clear did not finish into advance");
    a_latch_check: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == S_CHECK)
        else $error("accepted request not checked");
    a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && st.out_free) |=> state_reg == S_IDLE)
        else $error("finished request not handed to output");

endmodule

// ===== hdl/sparse_octree_voxel_insert.sv =====
// Sparse voxel octree builder. Each request is an insert, a node read or a color read and
// produces exactly one response. One request is handled at a time. An insert passes
// through accept, check, then for each level a node read issue, read data and update
// write with an advance step between levels, eight clear steps to zero each newly created
// child group, and a final step to load the response; a walk that stops early ends sooner.
// Reads pass through accept, check, read issue, read data and load; rejected or unused
// requests through accept, check and load. A waiting response holds the block in its
// final state; the response register lets the next request in while a response waits.
// After reset the root node is cleared before the first request is taken.
module sparse_octree_voxel_insert
    import soi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [DEPTH_W-1:0] cfg_wr_data,
    soi_req_if.sink            in_ch,
    soi_rsp_if.source          out_ch
);

    ctrl_cmd_t  cmd;
    dp_status_t st;

    soi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .st       (st),
        .cmd      (cmd)
    );

    soi_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_command  (in_ch.command),
        .in_code     (in_ch.voxel_code),
        .in_color    (in_ch.color),
        .in_index    (in_ch.read_index),
        .cmd         (cmd),
        .st          (st),
        .out_ch      (out_ch)
    );

endmodule
